// File: hdl/b64e_pkg.sv
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR    = 7'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    localparam logic [6:0] UPPER_BASE = 7'h41;
    localparam logic [6:0] LOWER_BASE = 7'h61;
    localparam logic [6:0] DIGIT_BASE = 7'h30;
    localparam logic [6:0] PLUS_CHAR  = 7'h2B;
    localparam logic [6:0] SLASH_CHAR = 7'h2F;
    localparam logic [6:0] LOWER_OFFSET = 7'd26;
    localparam logic [6:0] DIGIT_OFFSET = 7'd52;

    localparam logic [1:0] LAST_CHAR_IDX = 2'd3;

    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;
        logic        last;
    } group_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] sextet);
        logic [6:0] v;
        logic [6:0] ch;
        begin
            v = {1'b0, sextet & SEXTET_MASK};
            case (sextet) inside
                [6'd0:6'd25]:  ch = UPPER_BASE + v;
                [6'd26:6'd51]: ch = LOWER_BASE + v - LOWER_OFFSET;
                [6'd52:6'd61]: ch = DIGIT_BASE + v - DIGIT_OFFSET;
                6'd62:         ch = PLUS_CHAR;
                default:       ch = SLASH_CHAR;
            endcase
            return ch;
        end
    endfunction

endpackage

// File: hdl/b64e_front.sv
module b64e_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  logic [7:0]      data_byte,
    input  logic            final_byte,
    input  logic            q_full,
    output logic            q_push,
    output b64e_pkg::group_t q_group
);
    import b64e_pkg::*;

    logic [1:0] pending_count_reg;
    logic [1:0] pending_count_next;
    logic [7:0] pend0_reg;
    logic [7:0] pend1_reg;
    logic       accept;
    logic       group_done;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !byte_stall;
    assign group_done = final_byte || (pending_count_reg == 2'd2);
    assign q_push     = accept && group_done;

    always_comb
    begin
        q_group.nbytes = pending_count_reg + 2'd1;
        q_group.last   = final_byte;
        case (pending_count_reg)
            2'd0:    q_group.bits = {data_byte, 16'h0000};
            2'd1:    q_group.bits = {pend0_reg, data_byte, 8'h00};
            default: q_group.bits = {pend0_reg, pend1_reg, data_byte};
        endcase
    end

    always_comb
    begin
        pending_count_next = pending_count_reg;
        if (accept)
        begin
            pending_count_next = group_done ? 2'd0 : pending_count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_count_reg <= 2'd0;
        end
        else
        begin
            pending_count_reg <= pending_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !group_done)
        begin
            if (pending_count_reg == 2'd0)
            begin
                pend0_reg <= data_byte;
            end
            else
            begin
                pend1_reg <= data_byte;
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_count_reg != 2'd3)
        else $error("pending byte count out of range");

endmodule

// File: hdl/b64e_queue.sv
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64e_pkg::group_t push_group,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output b64e_pkg::group_t head_group
);
    import b64e_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_group = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_group;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("group queue overflow");

    a_push_taken: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("group pushed into full queue");

endmodule

// File: hdl/b64e_back.sv
module b64e_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  b64e_pkg::group_t head_group,
    output logic             pop,
    output logic             char_valid,
    input  logic             char_stall,
    output logic [6:0]       out_char,
    output logic             run_end,
    output logic             message_end
);
    import b64e_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       char_valid_reg;
    logic       char_valid_next;
    logic [6:0] out_char_reg;
    logic       run_end_reg;
    logic       message_end_reg;
    logic       load;
    logic       emit;
    logic [5:0] sextet;
    logic       is_pad;
    logic [6:0] ch;

    assign load = !char_valid_reg || !char_stall;
    assign emit = load && head_valid;
    assign pop  = emit && (idx_reg == LAST_CHAR_IDX);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = head_group.bits[23:18];
            2'd1:    sextet = head_group.bits[17:12];
            2'd2:    sextet = head_group.bits[11:6];
            default: sextet = head_group.bits[5:0];
        endcase
        is_pad = ((idx_reg == 2'd2) && (head_group.nbytes < 2'd2))
              || ((idx_reg == LAST_CHAR_IDX) && (head_group.nbytes < 2'd3));
        ch = is_pad ? PAD_CHAR : sextet_char(sextet);
    end

    always_comb
    begin
        idx_next        = idx_reg;
        char_valid_next = char_valid_reg;
        if (emit)
        begin
            idx_next        = idx_reg + 2'd1;
            char_valid_next = 1'b1;
        end
        else if (load)
        begin
            char_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= 2'd0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_char_reg    <= ch;
            run_end_reg     <= (idx_reg == LAST_CHAR_IDX);
            message_end_reg <= (idx_reg == LAST_CHAR_IDX) && head_group.last;
        end
    end

    assign char_valid  = char_valid_reg;
    assign out_char    = out_char_reg;
    assign run_end     = run_end_reg;
    assign message_end = message_end_reg;

    a_msg_end_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid_reg && message_end_reg |-> run_end_reg)
        else $error("message end off a run end");

    a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> head_valid)
        else $error("group left queue mid-run");

    a_run_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0)
        else $error("character index not wrapped after group");

endmodule

// File: hdl/base64_stream_encoder.sv
// Streaming Base64 encoder (standard alphabet, '=' padding). Bytes enter one
// per beat with final_byte on the last byte of a message; characters leave one
// per beat as 7-bit ASCII, run_end on the fourth character of each group and
// message_end on the last character of the message. The front takes a byte
// every cycle unless the group queue is full, and gathers groups of up to
// three bytes into a QUEUE_DEPTH-entry group queue, so it takes more bytes
// while the back drains that queue through the output register at one
// character per cycle unless char_stall holds it. Every group, also one
// closed early by final_byte, leaves as four characters, padded with '='.
// A closed group passes the group queue and then the output register.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [6:0] out_char,
    output logic       run_end,
    output logic       message_end
);
    import b64e_pkg::*;

    group_t push_group;
    group_t head_group;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   head_valid;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_group    (push_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_group (push_group),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_group (head_group)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_group  (head_group),
        .pop         (q_pop),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .run_end     (run_end),
        .message_end (message_end)
    );

endmodule
